[src/iac_pkg.sv]
// shared types, codes and field layout for the intrusion alarm controller
package iac_pkg;

  localparam int unsigned PinMaxChars = 8;
  localparam int unsigned PinMinChars = 4;
  localparam int unsigned CharW       = 8;
  localparam int unsigned PinW        = 64;
  localparam int unsigned LenW        = 4;
  localparam int unsigned DelayW      = 32;
  localparam int unsigned CountW      = 8;
  localparam int unsigned ReqW        = 3;
  localparam int unsigned ModeW       = 3;
  localparam int unsigned ReasonW     = 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;

  localparam logic [CharW-1:0] AsciiZero = 8'h30;
  localparam logic [CharW-1:0] AsciiNine = 8'h39;

  // request kinds
  localparam logic [ReqW-1:0] ReqArm    = 3'd0;
  localparam logic [ReqW-1:0] ReqDisarm = 3'd1;
  localparam logic [ReqW-1:0] ReqZone   = 3'd2;
  localparam logic [ReqW-1:0] ReqTick   = 3'd3;
  localparam logic [ReqW-1:0] ReqBegin  = 3'd4;

  // alarm reasons
  localparam logic [ReasonW-1:0] WhyNone    = 2'd0;
  localparam logic [ReasonW-1:0] WhyInstant = 2'd1;
  localparam logic [ReasonW-1:0] WhyTimeout = 2'd2;
  localparam logic [ReasonW-1:0] WhyTamper  = 2'd3;

  // reported mode codes
  localparam logic [ModeW-1:0] ModeCodeDisarmed = 3'd0;
  localparam logic [ModeW-1:0] ModeCodeExit     = 3'd1;
  localparam logic [ModeW-1:0] ModeCodeArmed    = 3'd2;
  localparam logic [ModeW-1:0] ModeCodeEntry    = 3'd3;
  localparam logic [ModeW-1:0] ModeCodeAlarm    = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgExitDelay  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEntryDelay = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxWrong   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPin        = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPinLen     = 3'd4;

  // stream layout
  localparam int unsigned InTdataW  = 104;
  localparam int unsigned OutTdataW = 48;

  typedef enum logic [4:0] {
    MODE_DISARMED = 5'b00001,
    MODE_EXIT     = 5'b00010,
    MODE_ARMED    = 5'b00100,
    MODE_ENTRY    = 5'b01000,
    MODE_ALARM    = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [DelayW-1:0] exit_delay_ms;
    logic [DelayW-1:0] entry_delay_ms;
    logic [CountW-1:0] max_wrong_pins;
    logic [PinW-1:0]   stored_pin;
    logic [LenW-1:0]   stored_pin_len;
  } cfg_t;

  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [PinW-1:0]   entered_pin;
    logic [LenW-1:0]   entered_len;
    logic              pin_absent;
    logic              zone_instant;
    logic [DelayW-1:0] elapsed_ms;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic [ModeW-1:0]   mode;
    logic [ReasonW-1:0] reason;
    logic [DelayW-1:0]  time_left_ms;
    logic [CountW-1:0]  wrong_pin_count;
    logic               config_valid;
  } result_t;

  function automatic logic [ModeW-1:0] mode_code(mode_e m);
    logic [ModeW-1:0] code;
    case (m)
      MODE_DISARMED: code = ModeCodeDisarmed;
      MODE_EXIT:     code = ModeCodeExit;
      MODE_ARMED:    code = ModeCodeArmed;
      MODE_ENTRY:    code = ModeCodeEntry;
      MODE_ALARM:    code = ModeCodeAlarm;
      default:       code = ModeCodeDisarmed;
    endcase
    return code;
  endfunction

endpackage

[src/iac_pin_check.sv]
// pin compare against the stored pin and configuration validity check
module iac_pin_check import iac_pkg::*; (
  input  cfg_t            cfg_i,
  input  logic [PinW-1:0] entered_pin_i,
  input  logic [LenW-1:0] entered_len_i,
  input  logic            pin_absent_i,
  output logic            pin_match_o,
  output logic            cfg_ok_o
);

  always_comb begin
    pin_match_o = !pin_absent_i && (entered_len_i == cfg_i.stored_pin_len) &&
                  (entered_len_i <= LenW'(PinMaxChars));
    for (int i = 0; i < PinMaxChars; i++) begin
      // only characters inside the entered length take part
      if (LenW'(i) < entered_len_i &&
          entered_pin_i[i*CharW +: CharW] != cfg_i.stored_pin[i*CharW +: CharW]) begin
        pin_match_o = 1'b0;
      end
    end
  end

  always_comb begin
    cfg_ok_o = (cfg_i.exit_delay_ms != '0) && (cfg_i.entry_delay_ms != '0) &&
               (cfg_i.max_wrong_pins != '0) &&
               (cfg_i.stored_pin_len >= LenW'(PinMinChars)) &&
               (cfg_i.stored_pin_len <= LenW'(PinMaxChars));
    for (int i = 0; i < PinMaxChars; i++) begin
      if (LenW'(i) < cfg_i.stored_pin_len &&
          (cfg_i.stored_pin[i*CharW +: CharW] < AsciiZero ||
           cfg_i.stored_pin[i*CharW +: CharW] > AsciiNine)) begin
        cfg_ok_o = 1'b0;
      end
    end
  end

endmodule

[src/iac_core.sv]
// alarm mode machine: state registers and per-request update
module iac_core import iac_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  req_t    req_i,
  input  logic    step_i,
  output result_t result_o
);

  mode_e              mode_q, mode_d;
  logic [ReasonW-1:0] reason_q, reason_d;
  logic [DelayW-1:0]  time_q, time_d;
  logic [CountW-1:0]  wrong_q, wrong_d;
  logic               valid_q, valid_d;
  logic               ok;
  logic               pin_match;
  logic               cfg_ok;
  logic [CountW-1:0]  wrong_inc;

  iac_pin_check u_pin_check (
    .cfg_i         (cfg_i),
    .entered_pin_i (req_i.entered_pin),
    .entered_len_i (req_i.entered_len),
    .pin_absent_i  (req_i.pin_absent),
    .pin_match_o   (pin_match),
    .cfg_ok_o      (cfg_ok)
  );

  // saturating attempt count, never wraps since it only counts up while below the limit
  assign wrong_inc = (wrong_q < cfg_i.max_wrong_pins) ? wrong_q + CountW'(1) : wrong_q;

  always_comb begin
    mode_d   = mode_q;
    reason_d = reason_q;
    time_d   = time_q;
    wrong_d  = wrong_q;
    valid_d  = valid_q;
    ok       = 1'b0;
    case (req_i.req_type)
      ReqArm: begin
        if (valid_q && mode_q == MODE_DISARMED && pin_match) begin
          mode_d   = MODE_EXIT;
          reason_d = WhyNone;
          time_d   = cfg_i.exit_delay_ms;
          wrong_d  = '0;
          ok       = 1'b1;
        end
      end
      ReqDisarm: begin
        if (valid_q) begin
          if (pin_match) begin
            mode_d   = MODE_DISARMED;
            reason_d = WhyNone;
            time_d   = '0;
            wrong_d  = '0;
            ok       = 1'b1;
          end else if (mode_q != MODE_DISARMED) begin
            wrong_d = wrong_inc;
            if (wrong_inc >= cfg_i.max_wrong_pins) begin
              mode_d   = MODE_ALARM;
              reason_d = WhyTamper;
              time_d   = '0;
            end
          end
        end
      end
      ReqZone: begin
        if (valid_q && (mode_q == MODE_ARMED || mode_q == MODE_ENTRY)) begin
          if (req_i.zone_instant) begin
            mode_d   = MODE_ALARM;
            reason_d = WhyInstant;
            time_d   = '0;
          end else if (mode_q == MODE_ARMED) begin
            mode_d = MODE_ENTRY;
            time_d = cfg_i.entry_delay_ms;
          end
        end
      end
      ReqTick: begin
        if (mode_q == MODE_EXIT || mode_q == MODE_ENTRY) begin
          if (req_i.elapsed_ms < time_q) begin
            time_d = time_q - req_i.elapsed_ms;
          end else begin
            time_d = '0;
            if (mode_q == MODE_EXIT) begin
              mode_d = MODE_ARMED;
            end else begin
              mode_d   = MODE_ALARM;
              reason_d = WhyTimeout;
            end
          end
        end
      end
      ReqBegin: begin
        valid_d  = cfg_ok;
        mode_d   = MODE_DISARMED;
        reason_d = WhyNone;
        time_d   = '0;
        wrong_d  = '0;
        ok       = cfg_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DISARMED;
      reason_q <= WhyNone;
      time_q   <= '0;
      wrong_q  <= '0;
      valid_q  <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      reason_q <= reason_d;
      time_q   <= time_d;
      wrong_q  <= wrong_d;
      valid_q  <= valid_d;
    end
  end

  // status after the request
  always_comb begin
    result_o.accepted        = ok;
    result_o.mode            = mode_code(mode_d);
    result_o.reason          = reason_d;
    result_o.time_left_ms    = time_d;
    result_o.wrong_pin_count = wrong_d;
    result_o.config_valid    = valid_d;
  end

endmodule

[src/intrusion_alarm_controller.sv]
// Intrusion alarm panel with exit and entry delays.
//
// Requests arrive on the s_axis stream, one request per transfer, with the
// request kind in tuser and the pin, length, flags and elapsed time in
// tdata. Every request yields exactly one status transfer on m_axis that
// reports the accepted flag, mode, alarm reason, remaining delay, wrong pin
// count and latched configuration validity after that request.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no request is in flight.
//
// A request is held in the input register while the mode update runs on it,
// and its status is captured in the output register when the request
// advances. Throughput is one request per cycle while m_axis does not stall;
// the compare, subtract and mode update in the core are combinational.
// When m_axis stalls the status holds in the output register and one more
// request waits in the input register; s_axis_tready_o then drops.
// Reset clears the mode machine to disarmed, not configured, and all
// configuration registers to zero.
module intrusion_alarm_controller import iac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // entered_pin[63:0], entered_len[67:64], pin_absent[68], zone_instant[69],
  // elapsed_ms[101:70], zero fill[103:102]
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // req_type[2:0]
  input  logic [ReqW-1:0]      s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // accepted[0], mode[3:1], reason[5:4], time_left_ms[37:6],
  // wrong_pin_count[45:38], config_valid[46], zero fill[47]
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t    cfg_q;
  req_t    in_q;
  logic    in_valid_q, in_valid_d;
  result_t out_q;
  logic    out_valid_q, out_valid_d;
  result_t result;
  logic    s_xfer;
  logic    advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgExitDelay:  cfg_q.exit_delay_ms  <= cfg_data_i[DelayW-1:0];
        CfgEntryDelay: cfg_q.entry_delay_ms <= cfg_data_i[DelayW-1:0];
        CfgMaxWrong:   cfg_q.max_wrong_pins <= cfg_data_i[CountW-1:0];
        CfgPin:        cfg_q.stored_pin     <= cfg_data_i[PinW-1:0];
        CfgPinLen:     cfg_q.stored_pin_len <= cfg_data_i[LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = s_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_q.req_type     <= s_axis_tuser_i;
      in_q.entered_pin  <= s_axis_tdata_i[63:0];
      in_q.entered_len  <= s_axis_tdata_i[67:64];
      in_q.pin_absent   <= s_axis_tdata_i[68];
      in_q.zone_instant <= s_axis_tdata_i[69];
      in_q.elapsed_ms   <= s_axis_tdata_i[101:70];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  iac_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .req_i    (in_q),
    .step_i   (advance),
    .result_o (result)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.config_valid, out_q.wrong_pin_count,
                            out_q.time_left_ms, out_q.reason, out_q.mode, out_q.accepted};

endmodule

[src/iac_checker.sv]
// port level checks for the intrusion alarm controller, bound to the top level
module iac_checker import iac_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o
);

  // a stalled status stays put until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("status changed while stalled");

  // disarmed always reports a clean state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3:1] == ModeCodeDisarmed |->
      m_axis_tdata_o[5:4] == WhyNone && m_axis_tdata_o[37:6] == '0 &&
      m_axis_tdata_o[45:38] == '0)
    else $error("disarmed with leftover state");

  // an alarm reason is shown exactly in alarm mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tdata_o[5:4] != WhyNone) == (m_axis_tdata_o[3:1] == ModeCodeAlarm)))
    else $error("alarm reason and mode disagree");

  // armed and alarm carry no running delay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o &&
      (m_axis_tdata_o[3:1] == ModeCodeArmed || m_axis_tdata_o[3:1] == ModeCodeAlarm) |->
      m_axis_tdata_o[37:6] == '0)
    else $error("delay left outside a delay mode");

  // nothing succeeds without a valid configuration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[46])
    else $error("request accepted while not configured");

endmodule

bind intrusion_alarm_controller iac_checker u_iac_checker (.*);

[tb/testbench.sv]
// stream-level regression for the intrusion alarm controller, checked against a built-in predictor
`timescale 1ns / 1ps

module testbench;
  import iac_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandPhases  = 18;
  localparam int unsigned PhaseItems  = 75;
  localparam int unsigned TailCycles  = 8;

  localparam logic [ReqW-1:0] ReqSpareLo = 3'd5;
  localparam logic [ReqW-1:0] ReqSpareHi = 3'd7;

  localparam int FlavorRandom = 0;
  localparam int FlavorLow    = 1;
  localparam int FlavorHigh   = 2;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 s_valid   = 1'b0;
  logic [InTdataW-1:0]  s_data    = '0;
  logic [ReqW-1:0]      s_user    = '0;
  logic                 m_ready   = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 cfg_ready_o;

  intrusion_alarm_controller DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin : reset_gen
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // predicted panel state and register copies
  logic [ModeW-1:0]   pm_mode   = ModeCodeDisarmed;
  logic [ReasonW-1:0] pm_reason = WhyNone;
  logic [DelayW-1:0]  pm_time   = '0;
  logic [CountW-1:0]  pm_wrong  = '0;
  logic               pm_valid  = 1'b0;

  logic [DelayW-1:0]  cf_exit  = '0;
  logic [DelayW-1:0]  cf_entry = '0;
  logic [CountW-1:0]  cf_max   = '0;
  logic [PinW-1:0]    cf_pin   = '0;
  logic [LenW-1:0]    cf_len   = '0;

  result_t     pending_status[$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 34;
  int unsigned rx_idle_pct = 66;
  bit          hold_ask    = 1'b0;

  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    req_t                req;
    bit                  fixed;
    result_t             want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic bit pin_ok(input logic [PinW-1:0] pin, input logic [LenW-1:0] len,
                                input logic absent);
    bit same;
    same = !absent && (len == cf_len) && (len <= PinMaxChars);
    for (int i = 0; i < PinMaxChars; i++) begin
      if (same && i < len && pin[i*CharW +: CharW] != cf_pin[i*CharW +: CharW]) same = 1'b0;
    end
    return same;
  endfunction

  function automatic bit settings_ok();
    bit good;
    good = cf_exit != 0 && cf_entry != 0 && cf_max != 0 &&
           cf_len >= PinMinChars && cf_len <= PinMaxChars;
    for (int i = 0; i < PinMaxChars; i++) begin
      if (good && i < cf_len &&
          (cf_pin[i*CharW +: CharW] < AsciiZero || cf_pin[i*CharW +: CharW] > AsciiNine))
        good = 1'b0;
    end
    return good;
  endfunction

  task automatic panel_clear();
    pm_mode   = ModeCodeDisarmed;
    pm_reason = WhyNone;
    pm_time   = '0;
    pm_wrong  = '0;
  endtask

  task automatic panel_alarm(input logic [ReasonW-1:0] why);
    pm_mode   = ModeCodeAlarm;
    pm_reason = why;
    pm_time   = '0;
  endtask

  task automatic alarm_step(input req_t r, output result_t res);
    logic ok;
    ok = 1'b0;
    case (r.req_type)
      ReqArm: begin
        if (pm_valid && pm_mode == ModeCodeDisarmed &&
            pin_ok(r.entered_pin, r.entered_len, r.pin_absent)) begin
          pm_mode   = ModeCodeExit;
          pm_reason = WhyNone;
          pm_time   = cf_exit;
          pm_wrong  = '0;
          ok        = 1'b1;
        end
      end
      ReqDisarm: begin
        if (pm_valid) begin
          if (pin_ok(r.entered_pin, r.entered_len, r.pin_absent)) begin
            panel_clear();
            ok = 1'b1;
          end else if (pm_mode != ModeCodeDisarmed) begin
            if (pm_wrong < cf_max) pm_wrong = pm_wrong + 1'b1;
            if (pm_wrong >= cf_max) panel_alarm(WhyTamper);
          end
        end
      end
      ReqZone: begin
        if (pm_valid && (pm_mode == ModeCodeArmed || pm_mode == ModeCodeEntry)) begin
          if (r.zone_instant) begin
            panel_alarm(WhyInstant);
          end else if (pm_mode == ModeCodeArmed) begin
            pm_mode = ModeCodeEntry;
            pm_time = cf_entry;
          end
        end
      end
      ReqTick: begin
        if (pm_mode == ModeCodeExit || pm_mode == ModeCodeEntry) begin
          if (r.elapsed_ms < pm_time) begin
            pm_time = pm_time - r.elapsed_ms;
          end else begin
            pm_time = '0;
            if (pm_mode == ModeCodeExit) pm_mode = ModeCodeArmed;
            else panel_alarm(WhyTimeout);
          end
        end
      end
      ReqBegin: begin
        pm_valid = settings_ok();
        panel_clear();
        ok = pm_valid;
      end
      default: ;
    endcase
    res.accepted        = ok;
    res.mode            = pm_mode;
    res.reason          = pm_reason;
    res.time_left_ms    = pm_time;
    res.wrong_pin_count = pm_wrong;
    res.config_valid    = pm_valid;
  endtask

  function automatic req_t mk_req(input logic [ReqW-1:0] kind, input logic [PinW-1:0] pin,
                                  input logic [LenW-1:0] len, input logic absent,
                                  input logic instant, input logic [DelayW-1:0] elapsed);
    req_t r;
    r.req_type     = kind;
    r.entered_pin  = pin;
    r.entered_len  = len;
    r.pin_absent   = absent;
    r.zone_instant = instant;
    r.elapsed_ms   = elapsed;
    return r;
  endfunction

  function automatic result_t status(input logic acc, input logic [ModeW-1:0] mode,
                                     input logic [ReasonW-1:0] why, input logic [DelayW-1:0] left,
                                     input logic [CountW-1:0] wrong, input logic valid);
    result_t s;
    s.accepted        = acc;
    s.mode            = mode;
    s.reason          = why;
    s.time_left_ms    = left;
    s.wrong_pin_count = wrong;
    s.config_valid    = valid;
    return s;
  endfunction

  function automatic void plan_req(input req_t r);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = '0;
    row.val    = '0;
    row.req    = r;
    row.fixed  = 1'b0;
    row.want   = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_fixed(input req_t r, input result_t want);
    plan_req(r);
    plan[$].fixed = 1'b1;
    plan[$].want  = want;
  endfunction

  function automatic void plan_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    row.req    = '0;
    row.fixed  = 1'b0;
    row.want   = '0;
    plan.push_back(row);
  endfunction

  function automatic logic [CfgDataW-1:0] setting_value(input int flavor,
                                                        input logic [CfgIdxW-1:0] idx);
    logic [CfgDataW-1:0] v;
    int unsigned c, pos;
    logic [CharW-1:0] bad;
    v = '0;
    c = $urandom_range(15);
    case (idx)
      CfgExitDelay, CfgEntryDelay: begin
        if (flavor == FlavorLow) v = 1;
        else if (flavor == FlavorHigh) v = 64'hFFFF_FFFF;
        else if (c == 0) v = 0;
        else if (c == 1) v = 1;
        else if (c == 2) v = 64'hFFFF_FFFF;
        else if (c == 3) v = CfgDataW'($urandom);
        else v = CfgDataW'($urandom_range(1, 400));
      end
      CfgMaxWrong: begin
        if (flavor == FlavorLow) v = 1;
        else if (flavor == FlavorHigh) v = 255;
        else if (c == 0) v = 0;
        else if (c == 1) v = 1;
        else if (c == 2) v = 255;
        else v = CfgDataW'($urandom_range(1, 6));
      end
      CfgPin: begin
        if (flavor == FlavorLow) v = CfgDataW'({4{AsciiZero}});
        else if (flavor == FlavorHigh) v = {8{AsciiNine}};
        else begin
          for (int i = 0; i < PinMaxChars; i++) begin
            v[i*CharW +: CharW] = CharW'($urandom_range(8'h30, 8'h39));
          end
          if (c == 0) begin
            v = {$urandom, $urandom};
          end else if (c < 3) begin
            // non-digit somewhere, maybe beyond the length
            pos = $urandom_range(0, PinMaxChars - 1);
            bad = CharW'($urandom_range(0, 255));
            if (bad >= AsciiZero && bad <= AsciiNine) bad = bad ^ 8'h80;
            v[pos*CharW +: CharW] = bad;
          end
        end
      end
      CfgPinLen: begin
        if (flavor == FlavorLow) v = CfgDataW'(PinMinChars);
        else if (flavor == FlavorHigh) v = CfgDataW'(PinMaxChars);
        else if (c < 2) v = CfgDataW'($urandom_range(0, PinMinChars - 1));
        else v = CfgDataW'($urandom_range(PinMinChars, PinMaxChars));
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // request biased by the predicted mode so that delays and alarms get reached
  function automatic req_t next_req();
    req_t r;
    int unsigned w, c, pos;
    r = mk_req(ReqTick, {$urandom, $urandom}, cf_len, 1'b0, $urandom_range(99) < 30, $urandom);
    w = $urandom_range(99);
    if (pm_mode == ModeCodeDisarmed) begin
      if (w < 50) r.req_type = ReqArm;
      else if (w < 62) r.req_type = ReqDisarm;
      else if (w < 72) r.req_type = ReqZone;
      else if (w < 86) r.req_type = ReqTick;
      else if (w < 95) r.req_type = ReqBegin;
      else r.req_type = ReqW'($urandom_range(ReqSpareLo, ReqSpareHi));
    end else begin
      if (w < 6) r.req_type = ReqArm;
      else if (w < 26) r.req_type = ReqDisarm;
      else if (w < 52) r.req_type = ReqZone;
      else if (w < 92) r.req_type = ReqTick;
      else if (w < 96) r.req_type = ReqBegin;
      else r.req_type = ReqW'($urandom_range(ReqSpareLo, ReqSpareHi));
    end
    c = $urandom_range(99);
    if (c < 78) begin
      for (int i = 0; i < PinMaxChars; i++) begin
        if (i < cf_len) r.entered_pin[i*CharW +: CharW] = cf_pin[i*CharW +: CharW];
      end
      if (c >= 60 && c < 70 && cf_len != 0) begin
        pos = $urandom_range(0, cf_len - 1);
        r.entered_pin[pos*CharW +: CharW] = r.entered_pin[pos*CharW +: CharW] ^
                                            CharW'($urandom_range(1, 255));
      end else if (c >= 70) begin
        r.pin_absent = 1'b1;
      end
    end else begin
      r.entered_len = LenW'($urandom_range(0, 15));
    end
    c = $urandom_range(99);
    if (c < 45) r.elapsed_ms = $urandom_range(0, pm_time);
    else if (c < 60) r.elapsed_ms = pm_time;
    else if (c < 70) r.elapsed_ms = '0;
    else if (c < 80) r.elapsed_ms = '1;
    return r;
  endfunction

  task automatic send_request(input req_t r, input bit fixed, input result_t want);
    result_t calc;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_valid <= 1'b1;
    s_data  <= {2'b00, r.elapsed_ms, r.zone_instant, r.pin_absent, r.entered_len, r.entered_pin};
    s_user  <= r.req_type;
    do @(posedge clk); while (!s_axis_tready_o);
    alarm_step(r, calc);
    pending_status.push_back(fixed ? want : calc);
  endtask

  // stop offering and wait for every outstanding status
  task automatic settle();
    s_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      CfgExitDelay:  cf_exit  = val[DelayW-1:0];
      CfgEntryDelay: cf_entry = val[DelayW-1:0];
      CfgMaxWrong:   cf_max   = val[CountW-1:0];
      CfgPin:        cf_pin   = val[PinW-1:0];
      CfgPinLen:     cf_len   = val[LenW-1:0];
      default: ;
    endcase
  endtask

  initial begin : ready_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : status_check
    result_t want;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (pending_status.size() == 0) begin
        $error("status transfer with nothing pending: %h", m_axis_tdata_o);
        err_count++;
      end else begin
        want = pending_status.pop_front();
        if (m_axis_tdata_o[0] !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, m_axis_tdata_o[0]);
          err_count++;
        end
        if (m_axis_tdata_o[3:1] !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, m_axis_tdata_o[3:1]);
          err_count++;
        end
        if (m_axis_tdata_o[5:4] !== want.reason) begin
          $error("reason: expected %0d, got %0d", want.reason, m_axis_tdata_o[5:4]);
          err_count++;
        end
        if (m_axis_tdata_o[37:6] !== want.time_left_ms) begin
          $error("time_left_ms: expected %0d, got %0d", want.time_left_ms,
                 m_axis_tdata_o[37:6]);
          err_count++;
        end
        if (m_axis_tdata_o[45:38] !== want.wrong_pin_count) begin
          $error("wrong_pin_count: expected %0d, got %0d", want.wrong_pin_count,
                 m_axis_tdata_o[45:38]);
          err_count++;
        end
        if (m_axis_tdata_o[46] !== want.config_valid) begin
          $error("config_valid: expected %0d, got %0d", want.config_valid, m_axis_tdata_o[46]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [PinW-1:0] pin_a, pin_b;
    bit in_cfg;
    pin_a  = 64'h0000_0000_3433_3231;
    pin_b  = 64'h3033_3435_3637_3839;
    in_cfg = 1'b0;

    // directed: reset state, refused requests, full delay and alarm walk
    plan_fixed(mk_req(ReqTick, '0, '0, 1'b0, 1'b0, '0),
               status(1'b0, ModeCodeDisarmed, WhyNone, '0, '0, 1'b0));
    plan_fixed(mk_req(ReqArm, '1, '1, 1'b1, 1'b1, '1),
               status(1'b0, ModeCodeDisarmed, WhyNone, '0, '0, 1'b0));
    plan_fixed(mk_req(ReqBegin, '0, '0, 1'b0, 1'b0, '0),
               status(1'b0, ModeCodeDisarmed, WhyNone, '0, '0, 1'b0));
    plan_cfg(CfgExitDelay, 100);
    plan_cfg(CfgEntryDelay, 50);
    plan_cfg(CfgMaxWrong, 3);
    plan_cfg(CfgPin, pin_a);
    plan_cfg(CfgPinLen, 4);
    plan_fixed(mk_req(ReqBegin, '0, '0, 1'b0, 1'b0, '0),
               status(1'b1, ModeCodeDisarmed, WhyNone, '0, '0, 1'b1));
    plan_fixed(mk_req(ReqDisarm, 64'h3533_3231, 4, 1'b0, 1'b0, '0),
               status(1'b0, ModeCodeDisarmed, WhyNone, '0, '0, 1'b1));
    plan_fixed(mk_req(ReqArm, pin_a, 5, 1'b0, 1'b0, '0),
               status(1'b0, ModeCodeDisarmed, WhyNone, '0, '0, 1'b1));
    // characters past the length must not matter
    plan_fixed(mk_req(ReqArm, 64'hDEAD_BEEF_3433_3231, 4, 1'b0, 1'b0, '0),
               status(1'b1, ModeCodeExit, WhyNone, 100, '0, 1'b1));
    plan_req(mk_req(ReqZone, '0, '0, 1'b0, 1'b1, '0));
    plan_req(mk_req(ReqTick, '0, '0, 1'b0, 1'b0, 40));
    plan_req(mk_req(ReqTick, '0, '0, 1'b0, 1'b0, '1));
    plan_req(mk_req(ReqZone, '0, '0, 1'b0, 1'b0, '0));
    plan_req(mk_req(ReqZone, '0, '0, 1'b0, 1'b0, '0));
    plan_req(mk_req(ReqDisarm, pin_a, 4, 1'b1, 1'b0, '0));
    plan_req(mk_req(ReqTick, '0, '0, 1'b0, 1'b0, 50));
    plan_req(mk_req(ReqDisarm, '0, 4, 1'b0, 1'b0, '0));
    plan_req(mk_req(ReqDisarm, pin_a, 3, 1'b0, 1'b0, '0));
    plan_req(mk_req(ReqDisarm, pin_a, 9, 1'b0, 1'b0, '0));
    plan_fixed(mk_req(ReqDisarm, pin_a, 4, 1'b0, 1'b0, '0),
               status(1'b1, ModeCodeDisarmed, WhyNone, '0, '0, 1'b1));
    plan_req(mk_req(ReqArm, pin_a, 4, 1'b0, 1'b0, '0));
    plan_req(mk_req(ReqTick, '0, '0, 1'b0, 1'b0, 100));
    plan_req(mk_req(ReqZone, '0, '0, 1'b0, 1'b1, '0));
    plan_req(mk_req(ReqSpareHi, '1, '1, 1'b1, 1'b1, '1));
    // limit dropped to zero after begin: first wrong pin is tamper
    plan_cfg(CfgMaxWrong, 0);
    plan_req(mk_req(ReqDisarm, '0, 4, 1'b0, 1'b0, '0));
    plan_fixed(mk_req(ReqDisarm, pin_a, 4, 1'b0, 1'b0, '0),
               status(1'b1, ModeCodeDisarmed, WhyNone, '0, '0, 1'b1));
    plan_cfg(CfgExitDelay, 64'hFFFF_FFFF);
    plan_cfg(CfgEntryDelay, 64'hFFFF_FFFF);
    plan_cfg(CfgMaxWrong, 255);
    plan_cfg(CfgPin, pin_b);
    plan_cfg(CfgPinLen, CfgDataW'(PinMaxChars));
    plan_fixed(mk_req(ReqBegin, '0, '0, 1'b0, 1'b0, '0),
               status(1'b1, ModeCodeDisarmed, WhyNone, '0, '0, 1'b1));
    plan_fixed(mk_req(ReqArm, pin_b, LenW'(PinMaxChars), 1'b0, 1'b0, '0),
               status(1'b1, ModeCodeExit, WhyNone, 32'hFFFF_FFFF, '0, 1'b1));

    do @(posedge clk); while (!rst_n);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        if (!in_cfg) settle();
        in_cfg = 1'b1;
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        if (in_cfg) cfg_valid <= 1'b0;
        in_cfg = 1'b0;
        send_request(plan[k].req, plan[k].fixed, plan[k].want);
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      settle();
      case (p / (RandPhases / 3))
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 66;
        end
        1: begin
          tx_idle_pct = 66;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int i = CfgExitDelay; i <= CfgPinLen; i++) begin
        write_reg(CfgIdxW'(i), setting_value(p == 0 ? FlavorLow :
                                             p == 1 ? FlavorHigh : FlavorRandom, CfgIdxW'(i)));
      end
      cfg_valid <= 1'b0;
      // now and then keep the validity latched by an older begin
      if (p % 5 != 4) send_request(mk_req(ReqBegin, {$urandom, $urandom},
                                          LenW'($urandom_range(0, 15)),
                                          1'($urandom_range(1)), 1'($urandom_range(1)),
                                          $urandom),
                                   1'b0, '0);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 2 && p % 3 == 1) begin
          settle();
          write_reg(CfgIdxW'($urandom_range(CfgExitDelay, CfgPinLen)), '0);
          cfg_index <= CfgIdxW'($urandom_range(CfgExitDelay, CfgPinLen));
          cfg_valid <= 1'b0;
        end
        if (n == 10 && p == 7) hold_ask = 1'b1;
        send_request(next_req(), 1'b0, '0);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk);
    if (err_count == 0 && pending_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
